[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the pick block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is asserted.
`define RPWR_ASSERT(label, ck, rstn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error(msg);

// Same, on the local clk and rst_n signals.
`define RPWR_ASSERT_CK(label, prop, msg) \
    `RPWR_ASSERT(label, clk, rst_n, prop, msg)

`endif

[hdl/rpwr_pkg.sv]
// Package for the random pick block: sizes, command codes, microcode format
// and the microcode program. No dependencies.
package rpwr_pkg;

    localparam int POOL_DEPTH     = 256;
    localparam int RANDOM_WIDTH   = 32;
    localparam int ADDR_W         = $clog2(POOL_DEPTH);
    localparam int VALUE_W        = 8;
    localparam int COUNT_W        = 9;
    localparam int CMD_W          = 2;
    localparam int BIT_CNT_W      = $clog2(RANDOM_WIDTH);
    localparam int STEP_W         = 4;

    localparam logic [COUNT_W-1:0] POOL_SIZE_RESET = COUNT_W'(256);

    localparam logic [CMD_W-1:0] CMD_PICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_PICK   = 4'd1;
    localparam step_t S_DIVW   = 4'd2;
    localparam step_t S_RDA    = 4'd3;
    localparam step_t S_RDB    = 4'd4;
    localparam step_t S_WRA    = 4'd5;
    localparam step_t S_WRB    = 4'd6;
    localparam step_t S_CANCEL = 4'd7;
    localparam step_t S_REFILL = 4'd8;
    localparam step_t S_NOP    = 4'd9;
    localparam step_t S_EMIT   = 4'd10;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_START,
        ACT_LATCH_SLOT,
        ACT_RD_SLOT,
        ACT_RD_LAST,
        ACT_WR_SLOT,
        ACT_WR_LAST,
        ACT_CANCEL,
        ACT_REFILL,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_IF_EMPTY,
        JMP_WAIT_DIV,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        logic  in_ready;
        act_t  act;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic busy;
        logic done;
    } urem_stat_t;

    // Microcode program, one control word per step.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        w = '{in_ready: 1'b0, act: ACT_NONE, jmp: JMP_GOTO, target: S_IDLE};
        unique case (step)
            S_IDLE:   w = '{1'b1, ACT_LOAD,       JMP_DISPATCH, S_IDLE};
            S_PICK:   w = '{1'b0, ACT_START,      JMP_IF_EMPTY, S_EMIT};
            S_DIVW:   w = '{1'b0, ACT_LATCH_SLOT, JMP_WAIT_DIV, S_IDLE};
            S_RDA:    w = '{1'b0, ACT_RD_SLOT,    JMP_NEXT,     S_IDLE};
            S_RDB:    w = '{1'b0, ACT_RD_LAST,    JMP_NEXT,     S_IDLE};
            S_WRA:    w = '{1'b0, ACT_WR_SLOT,    JMP_NEXT,     S_IDLE};
            S_WRB:    w = '{1'b0, ACT_WR_LAST,    JMP_GOTO,     S_EMIT};
            S_CANCEL: w = '{1'b0, ACT_CANCEL,     JMP_GOTO,     S_EMIT};
            S_REFILL: w = '{1'b0, ACT_REFILL,     JMP_GOTO,     S_EMIT};
            S_NOP:    w = '{1'b0, ACT_NONE,       JMP_GOTO,     S_EMIT};
            S_EMIT:   w = '{1'b0, ACT_EMIT,       JMP_WAIT_OUT, S_IDLE};
            default:  w = '{1'b0, ACT_NONE,       JMP_GOTO,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hdl/rpwr_in_if.sv]
// Command channel interface: valid/ready plus command and random word.
// Depends on rpwr_pkg.
interface rpwr_in_if
    import rpwr_pkg::*;
    ;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [RANDOM_WIDTH-1:0] random_word;

    modport source (output valid, output cmd, output random_word, input ready);
    modport sink   (input valid, input cmd, input random_word, output ready);
endinterface

[hdl/rpwr_out_if.sv]
// Result channel interface: valid/ready plus picked value, empty flag, count.
// Depends on rpwr_pkg.
interface rpwr_out_if
    import rpwr_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] picked_value;
    logic               pool_was_empty;
    logic [COUNT_W-1:0] remaining;

    modport source (output valid, output picked_value, output pool_was_empty,
                    output remaining, input ready);
    modport sink   (input valid, input picked_value, input pool_was_empty,
                    input remaining, output ready);
endinterface

[hdl/rpwr_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rpwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/rpwr_urem.sv]
// Iterative unsigned remainder of the random word by the pool count,
// one dividend bit per cycle. Depends on rpwr_pkg.
module rpwr_urem
    import rpwr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [RANDOM_WIDTH-1:0] dividend,
    input  logic [COUNT_W-1:0]      divisor,
    output logic [ADDR_W-1:0]       remainder,
    output urem_stat_t              stat
);
    logic [RANDOM_WIDTH-1:0] dvd_reg;
    logic [COUNT_W-1:0]      dvs_reg;
    logic [ADDR_W-1:0]       rem_reg;
    logic [BIT_CNT_W-1:0]    cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [COUNT_W-1:0]      shifted;
    logic [COUNT_W-1:0]      rem_next;

    // Shift in the next dividend bit; the partial remainder stays below the divisor.
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[RANDOM_WIDTH-1]};
        if (shifted >= dvs_reg)
        begin
            rem_next = shifted - dvs_reg;
        end
        else
        begin
            rem_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == BIT_CNT_W'(RANDOM_WIDTH - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == BIT_CNT_W'(RANDOM_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[RANDOM_WIDTH-2:0], 1'b0};
            rem_reg <= rem_next[ADDR_W-1:0];
        end
    end

    assign remainder = rem_reg;
    assign stat      = '{busy: busy_reg, done: done_reg};
endmodule

[hdl/random_pick_without_replacement.sv]
// Random pick without replacement: pool permutation, sequencer and result register.
// Depends on rpwr_pkg, rpwr_in_if, rpwr_out_if, rpwr_ram and rpwr_urem.
//
// Usage:
//   in_ch carries one command per transaction: pick, cancel last pick or refill,
//   with a random word used only by pick. out_ch returns exactly one result per
//   command: picked value, empty flag and the count of unpicked values left.
//   cfg_wr_en/cfg_wr_data write pool_size; write it only while idle and follow
//   it with a refill.
// Sequence:
//   A pick goes through accept, start, the remainder wait, the reads of the slot
//   and last entries, the writes of the slot and last entries, and emit. The
//   remainder unit works through the bits of the 32-bit random word, then hands
//   over the slot; the swap uses the pool RAM's write port and its separate read
//   port. The next command is accepted only after the previous one has left its emit
//   step. Cancel, refill, unused commands and a pick on an empty pool skip the remainder unit and the swap.
// Reset:
//   All pool entries read as the identity at once (per-entry valid bits), the
//   count is 256 and pool_size is 256. No clearing pass is needed.
// Stalls:
//   The result register holds a finished result until out_ch takes it; the next
//   command is still accepted meanwhile and waits in its last step only when a
//   second result is ready before the first is taken.
module random_pick_without_replacement
    import rpwr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    rpwr_in_if.sink            in_ch,
    rpwr_out_if.source         out_ch
);
    // Sequencer
    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   in_fire;
    logic   out_free;

    // Datapath state
    logic [COUNT_W-1:0]      pool_size_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      eff_size;
    logic [CMD_W-1:0]        cmd_reg;
    logic [RANDOM_WIDTH-1:0] word_reg;
    logic [ADDR_W-1:0]       slot_reg;
    logic [VALUE_W-1:0]      tmp_reg;
    logic [VALUE_W-1:0]      picked_reg;
    logic                    empty_reg;
    logic [POOL_DEPTH-1:0]   valid_reg;
    logic [ADDR_W-1:0]       last_addr;

    // Pool RAM access
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic               rd_valid_reg;
    logic [VALUE_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] pool_data;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;

    // Remainder unit
    logic              div_start;
    logic [ADDR_W-1:0] div_rem;
    urem_stat_t        div_stat;

    // Result register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_picked_reg;
    logic               out_empty_reg;
    logic [COUNT_W-1:0] out_remaining_reg;

    assign uw       = ucode(pc_reg);
    assign in_fire  = in_ch.valid && uw.in_ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    // Sizes above the pool depth saturate.
    assign eff_size  = (pool_size_reg > COUNT_W'(POOL_DEPTH)) ? COUNT_W'(POOL_DEPTH)
                                                              : pool_size_reg;
    assign last_addr = ADDR_W'(count_reg - 1'b1);

    // Step counter: advance, jump or hold as the control word says.
    always_comb
    begin
        pc_next = pc_reg;
        unique case (uw.jmp)
            JMP_NEXT:     pc_next = pc_reg + 1'b1;
            JMP_GOTO:     pc_next = uw.target;
            JMP_DISPATCH:
            begin
                if (in_fire)
                begin
                    unique case (in_ch.cmd)
                        CMD_PICK:   pc_next = S_PICK;
                        CMD_CANCEL: pc_next = S_CANCEL;
                        CMD_REFILL: pc_next = S_REFILL;
                        default:    pc_next = S_NOP;
                    endcase
                end
            end
            JMP_IF_EMPTY: pc_next = (count_reg == '0) ? uw.target : pc_reg + 1'b1;
            JMP_WAIT_DIV: pc_next = div_stat.done ? pc_reg + 1'b1 : pc_reg;
            JMP_WAIT_OUT: pc_next = out_free ? uw.target : pc_reg;
            default:      pc_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // Pool reads return the RAM word, or the entry's own index until written.
    assign rd_addr   = (uw.act == ACT_RD_LAST) ? last_addr : slot_reg;
    assign pool_data = rd_valid_reg ? ram_rdata : rd_addr_reg;

    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= rd_addr;
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // Swap: slot gets the last unpicked value, last gets the picked one.
    assign ram_we    = (uw.act == ACT_WR_SLOT) || (uw.act == ACT_WR_LAST);
    assign ram_waddr = (uw.act == ACT_WR_LAST) ? last_addr : slot_reg;
    assign ram_wdata = (uw.act == ACT_WR_LAST) ? tmp_reg : pool_data;

    rpwr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign div_start = (uw.act == ACT_START) && (count_reg != '0);

    rpwr_urem u_urem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (word_reg),
        .divisor   (count_reg),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // Control state: size register, count, valid bits, result staging.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_SIZE_RESET;
            count_reg     <= COUNT_W'(POOL_DEPTH);
            valid_reg     <= '0;
            picked_reg    <= '0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pool_size_reg <= cfg_wr_data;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            case (uw.act)
                ACT_LOAD:
                begin
                    if (in_fire)
                    begin
                        picked_reg <= '0;
                        empty_reg  <= 1'b0;
                    end
                end
                ACT_START:
                begin
                    if (count_reg == '0)
                    begin
                        empty_reg <= 1'b1;
                    end
                end
                ACT_WR_LAST:
                begin
                    count_reg  <= count_reg - 1'b1;
                    picked_reg <= tmp_reg;
                end
                ACT_CANCEL:
                begin
                    if (count_reg < eff_size)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ACT_REFILL:
                begin
                    valid_reg <= '0;
                    count_reg <= eff_size;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload staging: command capture, slot and first swap value.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= in_ch.cmd;
            word_reg <= in_ch.random_word;
        end
        if (uw.act == ACT_LATCH_SLOT)
        begin
            slot_reg <= div_rem;
        end
        if (uw.act == ACT_RD_LAST)
        begin
            tmp_reg <= pool_data;
        end
    end

    // Result register: load in the emit step once free, drop on transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((uw.act == ACT_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((uw.act == ACT_EMIT) && out_free)
        begin
            out_picked_reg    <= (cmd_reg == CMD_PICK) ? picked_reg : '0;
            out_empty_reg     <= (cmd_reg == CMD_PICK) ? empty_reg : 1'b0;
            out_remaining_reg <= count_reg;
        end
    end

    assign in_ch.ready           = uw.in_ready;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.picked_value   = out_picked_reg;
    assign out_ch.pool_was_empty = out_empty_reg;
    assign out_ch.remaining      = out_remaining_reg;
endmodule

[hdl/rpwr_checker.sv]
// Port-level checker for the random pick block, bound to the top level.
// Depends on rpwr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpwr_checker
    import rpwr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VALUE_W-1:0] out_picked_value,
    input logic               out_pool_was_empty,
    input logic [COUNT_W-1:0] out_remaining
);
    // A stalled result holds its value.
    `RPWR_ASSERT_CK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_picked_value) && $stable(out_pool_was_empty) && $stable(out_remaining), "result changed while stalled")

    // The sequencer leaves its accept step right after a transaction.
    `RPWR_ASSERT_CK(a_in_one_per_step, in_valid && in_ready |=> !in_ready, "two commands accepted back to back")

    // No result can appear the cycle after a command is accepted.
    `RPWR_ASSERT(a_min_latency, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid), "result too early")

    // An empty pick reports nothing picked and nothing left.
    `RPWR_ASSERT_CK(a_empty_result, out_valid && out_pool_was_empty |-> out_picked_value == '0 && out_remaining == '0, "inconsistent empty result")
endmodule

bind random_pick_without_replacement rpwr_checker u_rpwr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_picked_value   (out_ch.picked_value),
    .out_pool_was_empty (out_ch.pool_was_empty),
    .out_remaining      (out_ch.remaining)
);
